// File: rtl/core/lcbs_pkg.sv
// Package for the LED clock with button set: register indexes, reset values,
// button phase codes and dial constants.
// No dependencies; imported by led_clock_with_button_set.
package lcbs_pkg;

    // register indexes on the configuration port (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_NORMAL    = 3'd1,
        REG_FAST      = 3'd2,
        REG_LONG      = 3'd3,
        REG_VLONG     = 3'd4,
        REG_IDLE_TMO  = 3'd5
    } reg_index_t;

    localparam int unsigned ADDR_W = 5;

    // register reset values
    localparam logic [9:0]  DEBOUNCE_RST = 10'd100;
    localparam logic [15:0] NORMAL_RST   = 16'd3906;
    localparam logic [15:0] FAST_RST     = 16'd10;
    localparam logic [13:0] LONG_RST     = 14'd3906;
    localparam logic [13:0] VLONG_RST    = 14'd7812;
    localparam logic [15:0] IDLE_TMO_RST = 16'd65000;

    // dial constants
    localparam logic [11:0] SECS_LAST    = 12'd3599;
    localparam logic [11:0] SECS_HOUR    = 12'd3600;
    localparam logic [11:0] SECS_MINUTE  = 12'd59;
    localparam logic [3:0]  HOUR_LAST    = 4'd11;
    localparam logic [3:0]  HOUR_RST     = 4'd9;
    localparam logic [13:0] PRESS_MAX    = 14'd16383;

    // seconds to minutes: (s * 4370) >> 18 is exact for s below 3600
    localparam logic [12:0] MIN_RECIP    = 13'd4370;
    localparam int unsigned MIN_SHIFT    = 18;

    // button machine phases, one-hot
    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_DEBOUNCE = 6'b000010,
        PH_COUNT    = 6'b000100,
        PH_SHORT    = 6'b001000,
        PH_LONG     = 6'b010000,
        PH_VLONG    = 6'b100000
    } phase_t;

endpackage

// File: rtl/core/led_clock_with_button_set.sv
// LED clock with a single set button: tick divider, seconds and hours counters,
// LED group decode, button debounce and hold classification, configuration port.
// Depends on lcbs_pkg.

// Each transaction on the s_ side is one timer tick carrying the raw button
// level in s_tdata bit 0. The block accepts one tick every clock cycle and
// returns one transaction per tick on the m_ side in the next cycle, holding the
// 19 LED latches and the set-mode and fast-mode flags as they stand after that
// tick. All counters are updated in the cycle the tick is accepted; the only
// thing that stops s_tready is a result still held in the output register by
// m_tready low. Registers on the APB port (byte addresses 0x00..0x14):
// debounce, normal period, fast period, long press, very long press and idle
// timeout; write them only while no ticks are flowing.
module led_clock_with_button_set (
    input  logic                        aclk,
    input  logic                        aresetn,
    // tick channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [0] button_down, [7:1] zero
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [7:0] minute_group_leds, [12:8] hour_group_leds, [18:13] quarter_group_leds,
    // [19] setting_hours, [20] fast_running, [23:21] zero
    output logic [23:0]                 m_tdata,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcbs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lcbs_pkg::*;

    // decode minute of hour and hour of twelve into the LED groups
    function automatic logic [18:0] redraw(input logic [5:0] minute, input logic [3:0] hour);
        logic [1:0] q;
        logic [3:0] r15;
        logic [1:0] f;
        logic [2:0] r5;
        logic [1:0] h3;
        logic [1:0] h1;
        logic [7:0] gm;
        logic [4:0] gh;
        logic [5:0] gq;
        q   = (minute >= 6'd45) ? 2'd3 : (minute >= 6'd30) ? 2'd2 :
              (minute >= 6'd15) ? 2'd1 : 2'd0;
        r15 = (minute >= 6'd45) ? 4'(minute - 6'd45) : (minute >= 6'd30) ? 4'(minute - 6'd30) :
              (minute >= 6'd15) ? 4'(minute - 6'd15) : minute[3:0];
        f   = (r15 >= 4'd10) ? 2'd2 : (r15 >= 4'd5) ? 2'd1 : 2'd0;
        r5  = (r15 >= 4'd10) ? 3'(r15 - 4'd10) : (r15 >= 4'd5) ? 3'(r15 - 4'd5) : r15[2:0];
        h3  = (hour >= 4'd9) ? 2'd3 : (hour >= 4'd6) ? 2'd2 : (hour >= 4'd3) ? 2'd1 : 2'd0;
        h1  = (hour >= 4'd9) ? 2'(hour - 4'd9) : (hour >= 4'd6) ? 2'(hour - 4'd6) :
              (hour >= 4'd3) ? 2'(hour - 4'd3) : hour[1:0];
        gm  = (8'd1 << r5) | (8'd1 << (3'd5 + {1'b0, f}));
        gh  = 5'd1 << h1;
        gq  = 6'd1 << q;
        if (h3 < 2'd2) begin
            gh = gh | (5'd1 << (3'd3 + {1'b0, h3}));
        end else begin
            gq = gq | (6'd1 << (3'd2 + {1'b0, h3}));
        end
        return {gq, gh, gm};
    endfunction

    // configuration registers
    logic [9:0]  debounce_reg;
    logic [15:0] normal_reg;
    logic [15:0] fast_reg;
    logic [13:0] long_reg;
    logic [13:0] vlong_reg;
    logic [15:0] idle_tmo_reg;

    // clock and button state
    logic [15:0] divider_reg, divider_next;
    logic [11:0] seconds_reg, seconds_next;
    logic [3:0]  hour_reg, hour_next;
    phase_t      phase_reg, phase_next;
    logic [13:0] press_reg, press_next;
    logic [15:0] idle_reg, idle_next;
    logic        hours_sel_reg, hours_sel_next;
    logic        fast_sel_reg, fast_sel_next;
    logic [18:0] led_reg, led_next;

    // result register
    logic        out_valid_reg;
    logic [20:0] out_data_reg;

    logic        in_acc;
    logic        cfg_wr;
    logic        pressed;
    logic [15:0] period;
    logic [16:0] limit;
    logic        rollover;
    logic [11:0] sec_roll;
    logic [11:0] sec_base;
    logic [3:0]  hour_roll;
    logic [24:0] min_prod;
    logic [5:0]  minute;
    logic        timeout;
    phase_t      phase_a;
    logic        hours_sel_a;
    logic [13:0] press_inc;
    logic [12:0] sec_add;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign pressed  = s_tdata[0];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

    // read back the registers
    always_comb begin
        case (paddr[4:2])
            REG_DEBOUNCE: prdata = {22'd0, debounce_reg};
            REG_NORMAL:   prdata = {16'd0, normal_reg};
            REG_FAST:     prdata = {16'd0, fast_reg};
            REG_LONG:     prdata = {18'd0, long_reg};
            REG_VLONG:    prdata = {18'd0, vlong_reg};
            REG_IDLE_TMO: prdata = {16'd0, idle_tmo_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // divider and seconds rollover
    assign period    = fast_sel_reg ? fast_reg : normal_reg;
    assign limit     = {1'b0, period} + {16'd0, (seconds_reg[1:0] == 2'b00)};
    assign rollover  = {1'b0, divider_reg} >= limit;
    assign sec_roll  = (seconds_reg == SECS_LAST) ? 12'd0 : 12'(seconds_reg + 12'd1);
    assign hour_roll = (sec_roll != 12'd0) ? hour_reg :
                       (hour_reg == HOUR_LAST) ? 4'd0 : 4'(hour_reg + 4'd1);
    assign min_prod  = 25'(sec_roll) * 25'(MIN_RECIP);
    assign minute    = min_prod[MIN_SHIFT+5:MIN_SHIFT];

    // idle timeout, checked ahead of the button machine
    always_comb begin
        idle_next   = pressed ? 16'd1 : 16'(idle_reg + 16'd1);
        timeout     = (idle_next == idle_tmo_reg);
        phase_a     = phase_reg;
        hours_sel_a = hours_sel_reg;
        if (timeout) begin
            idle_next   = 16'd0;
            phase_a     = PH_IDLE;
            hours_sel_a = 1'b0;
        end
    end

    // a short press adds its minute to the seconds as they stand after this tick
    assign press_inc = (press_reg < PRESS_MAX) ? 14'(press_reg + 14'd1) : press_reg;
    assign sec_base  = rollover ? sec_roll : seconds_reg;
    assign sec_add   = {1'b0, sec_base} + {1'b0, SECS_MINUTE};

    // clock step and button machine
    always_comb begin
        divider_next   = rollover ? 16'd0 : 16'(divider_reg + 16'd1);
        seconds_next   = sec_base;
        hour_next      = rollover ? hour_roll : hour_reg;
        led_next       = rollover ? redraw(minute, hour_roll) : led_reg;
        phase_next     = phase_a;
        press_next     = press_reg;
        hours_sel_next = hours_sel_a;
        fast_sel_next  = fast_sel_reg;
        case (phase_a)
            PH_IDLE: begin
                if (pressed) begin
                    press_next = 14'd0;
                    phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (press_reg >= {4'd0, debounce_reg}) begin
                    phase_next = PH_COUNT;
                    press_next = 14'd0;
                end else begin
                    press_next = 14'(press_reg + 14'd1);
                end
            end
            PH_COUNT: begin
                press_next = press_inc;
                if (!pressed) begin
                    if (press_inc < long_reg) begin
                        phase_next = PH_SHORT;
                    end else if (press_inc < vlong_reg) begin
                        phase_next = PH_LONG;
                    end else begin
                        phase_next = PH_VLONG;
                    end
                end
            end
            PH_SHORT: begin
                divider_next = 16'(period - 16'd1);
                if (!hours_sel_a) begin
                    if (sec_add >= {1'b0, SECS_HOUR}) begin
                        seconds_next = 12'(sec_add - {1'b0, SECS_HOUR});
                        hour_next    = (hour_next == HOUR_LAST) ? 4'd0 : 4'(hour_next + 4'd1);
                    end else begin
                        seconds_next = sec_add[11:0];
                    end
                end else begin
                    hour_next = (hour_next == HOUR_LAST) ? 4'd0 : 4'(hour_next + 4'd1);
                end
                phase_next = PH_IDLE;
            end
            PH_LONG: begin
                hours_sel_next = !hours_sel_a;
                phase_next     = PH_IDLE;
            end
            PH_VLONG: begin
                fast_sel_next = !fast_sel_reg;
                phase_next    = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
            normal_reg   <= NORMAL_RST;
            fast_reg     <= FAST_RST;
            long_reg     <= LONG_RST;
            vlong_reg    <= VLONG_RST;
            idle_tmo_reg <= IDLE_TMO_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_DEBOUNCE: debounce_reg <= pwdata[9:0];
                REG_NORMAL:   normal_reg   <= pwdata[15:0];
                REG_FAST:     fast_reg     <= pwdata[15:0];
                REG_LONG:     long_reg     <= pwdata[13:0];
                REG_VLONG:    vlong_reg    <= pwdata[13:0];
                REG_IDLE_TMO: idle_tmo_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // advance the state on every accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_reg   <= 16'(NORMAL_RST - 16'd1);
            seconds_reg   <= 12'd0;
            hour_reg      <= HOUR_RST;
            phase_reg     <= PH_IDLE;
            press_reg     <= 14'd0;
            idle_reg      <= 16'd1;
            hours_sel_reg <= 1'b0;
            fast_sel_reg  <= 1'b0;
            led_reg       <= 19'd0;
        end else if (in_acc) begin
            divider_reg   <= divider_next;
            seconds_reg   <= seconds_next;
            hour_reg      <= hour_next;
            phase_reg     <= phase_next;
            press_reg     <= press_next;
            idle_reg      <= idle_next;
            hours_sel_reg <= hours_sel_next;
            fast_sel_reg  <= fast_sel_next;
            led_reg       <= led_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_data_reg <= {fast_sel_next, hours_sel_next, led_next};
        end
    end

    // checks
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("tick accepted while result held");

    a_dial_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seconds_reg < SECS_HOUR) && (hour_reg <= HOUR_LAST))
        else $error("clock counters out of range");

    a_led_groups: assert property (@(posedge aclk) disable iff (!aresetn)
        (led_reg != 19'd0) |-> ($onehot(led_reg[4:0]) && $onehot(led_reg[7:5]) &&
                                $onehot(led_reg[10:8]) && $onehot(led_reg[16:13]) &&
                                $onehot({led_reg[18:17], led_reg[12:11]})))
        else $error("LED groups not one-hot");

    a_long_swaps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && phase_reg == PH_LONG && !timeout) |=> (hours_sel_reg != $past(hours_sel_reg)))
        else $error("long press did not swap set mode");

endmodule
